// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the mesh face expander.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IMF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IMF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg
// Shared constants and types of the indexed mesh face expander.
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

	localparam int VERTEX_CAPACITY = 4096;
	localparam int NORMAL_CAPACITY = 4096;
	localparam int VERTEX_WORDS    = 3 * VERTEX_CAPACITY;
	localparam int NORMAL_WORDS    = 3 * NORMAL_CAPACITY;

	localparam int V_IDX_W  = (VERTEX_CAPACITY > 1) ? $clog2(VERTEX_CAPACITY) : 1;
	localparam int N_IDX_W  = (NORMAL_CAPACITY > 1) ? $clog2(NORMAL_CAPACITY) : 1;
	localparam int V_CNT_W  = $clog2(VERTEX_CAPACITY + 1);
	localparam int N_CNT_W  = $clog2(NORMAL_CAPACITY + 1);
	localparam int V_ADDR_W = $clog2(VERTEX_WORDS);
	localparam int N_ADDR_W = $clog2(NORMAL_WORDS);

	localparam int QUEUE_DEPTH = 2;

	// item function codes
	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_V = 2'd1;
	localparam logic [1:0] FUNC_LOAD_N = 2'd2;
	localparam logic [1:0] FUNC_FACE   = 2'd3;

	// decode modes
	localparam logic [2:0] MODE_PLAIN = 3'd2;
	localparam logic [2:0] MODE_XOR   = 3'd3;
	localparam logic [2:0] MODE_DELTA = 3'd4;

	// error codes
	localparam logic [2:0] ERR_OK    = 3'd0;
	localparam logic [2:0] ERR_DELTA = 3'd1;
	localparam logic [2:0] ERR_NREF  = 3'd2;
	localparam logic [2:0] ERR_VREF  = 3'd3;
	localparam logic [2:0] ERR_FULL  = 3'd4;

	typedef struct packed {
		logic [2:0]              err;
		logic [N_IDX_W-1:0]      nidx;
		logic [2:0][V_IDX_W-1:0] vidx;
		logic [15:0]             attr;
	} face_job_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  err;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic                we;
		logic [V_ADDR_W-1:0] addr;
		logic [31:0]         data;
	} vtx_wr_t;

	typedef struct packed {
		logic                we;
		logic [N_ADDR_W-1:0] addr;
		logic [31:0]         data;
	} nrm_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/imf_ram.sv =====
// ----------------------------------------------------------------------------
// imf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/imf_queue.sv =====
// ----------------------------------------------------------------------------
// imf_queue
// Short job queue between the decode front end and the word emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire imf_pkg::face_job_t push_job,
	output      logic              full,
	input  wire logic              pop,
	output      logic              not_empty,
	output      imf_pkg::face_job_t head_job
);

	localparam int PTR_W = $clog2(imf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(imf_pkg::QUEUE_DEPTH + 1);

	imf_pkg::face_job_t slot_q [imf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(imf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/imf_front.sv =====
// ----------------------------------------------------------------------------
// imf_front
// Accepts items, loads dictionaries, decodes and checks face references.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_wdata,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [31:0]        data_word,
	input  wire logic [31:0]        vertex_ref_a,
	input  wire logic [31:0]        vertex_ref_b,
	input  wire logic [31:0]        vertex_ref_c,
	input  wire logic [15:0]        attribute_bits,
	input  wire logic               drained,
	input  wire logic               q_full,
	output      logic               job_push,
	output      imf_pkg::face_job_t job,
	output      imf_pkg::vtx_wr_t   vtx_wr,
	output      imf_pkg::nrm_wr_t   nrm_wr
);

	typedef enum logic [1:0] {F_IDLE, F_DEC, F_PUSH} fstate_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] chain;
		logic [31:0] index;
	} dec_t;

	function automatic dec_t decode_ref(input logic [2:0] mode, input logic [31:0] raw,
		input logic [31:0] chain);
		dec_t        r;
		logic [33:0] sum;
		r.ok    = 1'b1;
		r.chain = chain;
		r.index = raw;
		// zigzag: odd codes are negative deltas
		sum = raw[0] ? ({2'b00, chain} - {3'b000, raw[31:1]} - 34'd1)
		             : ({2'b00, chain} + {3'b000, raw[31:1]});
		if (mode == imf_pkg::MODE_XOR) begin
			r.chain = chain ^ raw;
			r.index = chain ^ raw;
		end else if (mode == imf_pkg::MODE_DELTA) begin
			if (sum[33] || sum[32]) begin
				r.ok    = 1'b0;
				r.index = '0;
			end else begin
				r.chain = sum[31:0];
				r.index = sum[31:0];
			end
		end
		return r;
	endfunction

	localparam int V_CNT_W_L = imf_pkg::V_CNT_W;
	localparam int N_CNT_W_L = imf_pkg::N_CNT_W;

	fstate_t state_q;
	logic [2:0] mode_q;
	logic [2:0] sticky_q;

	logic [V_CNT_W_L-1:0] v_ent_q;
	logic [N_CNT_W_L-1:0] n_ent_q;

	logic [1:0] v_phase_q;
	logic [1:0] n_phase_q;
	logic [imf_pkg::V_ADDR_W-1:0] v_addr_q;
	logic [imf_pkg::N_ADDR_W-1:0] n_addr_q;
	logic [31:0] v_comp_q [3];
	logic [31:0] n_comp_q [3];
	logic [31:0] v_chain_q;
	logic [31:0] n_chain_q;

	logic [31:0] data_q;
	logic [31:0] vref_q [3];
	logic [15:0] attr_q;
	logic [1:0]  step_q;
	logic        dfail_q;
	logic        nbad_q;
	logic        vbad_q;
	logic [imf_pkg::N_IDX_W-1:0]      nidx_q;
	logic [2:0][imf_pkg::V_IDX_W-1:0] vidx_q;

	logic        accept;
	logic        xor_mode;
	logic        v_full;
	logic        n_full;
	logic [31:0] v_word;
	logic [31:0] n_word;
	logic [31:0] raw_sel;
	logic [31:0] chain_sel;
	dec_t        dec;
	logic        bad_now;
	logic [2:0]  code_now;
	logic [2:0]  err_new;

	assign in_stall = (state_q != F_IDLE) || ((func == imf_pkg::FUNC_START) && !drained);
	assign accept   = in_valid && !in_stall;
	assign xor_mode = (mode_q == imf_pkg::MODE_XOR) || (mode_q == imf_pkg::MODE_DELTA);
	assign v_full   = (v_ent_q == V_CNT_W_L'(imf_pkg::VERTEX_CAPACITY));
	assign n_full   = (n_ent_q == N_CNT_W_L'(imf_pkg::NORMAL_CAPACITY));
	assign v_word   = xor_mode ? (data_word ^ v_comp_q[v_phase_q]) : data_word;
	assign n_word   = xor_mode ? (data_word ^ n_comp_q[n_phase_q]) : data_word;

	assign vtx_wr.we   = accept && (func == imf_pkg::FUNC_LOAD_V) && !v_full;
	assign vtx_wr.addr = v_addr_q;
	assign vtx_wr.data = v_word;
	assign nrm_wr.we   = accept && (func == imf_pkg::FUNC_LOAD_N) && !n_full;
	assign nrm_wr.addr = n_addr_q;
	assign nrm_wr.data = n_word;

	always_comb begin
		case (step_q)
			2'd0:    raw_sel = data_q;
			2'd1:    raw_sel = vref_q[0];
			2'd2:    raw_sel = vref_q[1];
			default: raw_sel = vref_q[2];
		endcase
	end

	assign chain_sel = (step_q == 2'd0) ? n_chain_q : v_chain_q;
	assign dec       = decode_ref(mode_q, raw_sel, chain_sel);
	assign bad_now   = (step_q == 2'd0) ? (dec.index >= 32'(n_ent_q))
	                                    : (dec.index >= 32'(v_ent_q));

	// delta errors beat normal errors beat vertex errors
	assign code_now = dfail_q ? imf_pkg::ERR_DELTA :
	                  nbad_q  ? imf_pkg::ERR_NREF  :
	                  vbad_q  ? imf_pkg::ERR_VREF  : imf_pkg::ERR_OK;
	assign err_new  = (sticky_q != imf_pkg::ERR_OK) ? sticky_q : code_now;

	assign job_push  = (state_q == F_PUSH) && !q_full;
	assign job.err   = err_new;
	assign job.nidx  = (err_new == imf_pkg::ERR_OK) ? nidx_q : '0;
	assign job.vidx  = (err_new == imf_pkg::ERR_OK) ? vidx_q : '0;
	assign job.attr  = attr_q;

	always_ff @(posedge clk) begin
		if (accept && (func == imf_pkg::FUNC_FACE)) begin
			data_q    <= data_word;
			vref_q[0] <= vertex_ref_a;
			vref_q[1] <= vertex_ref_b;
			vref_q[2] <= vertex_ref_c;
			attr_q    <= attribute_bits;
		end
		if (state_q == F_DEC) begin
			if (step_q == 2'd0) begin
				nidx_q <= dec.index[imf_pkg::N_IDX_W-1:0];
			end else begin
				vidx_q[step_q - 2'd1] <= dec.index[imf_pkg::V_IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			mode_q    <= imf_pkg::MODE_PLAIN;
			sticky_q  <= imf_pkg::ERR_OK;
			v_ent_q   <= '0;
			n_ent_q   <= '0;
			v_phase_q <= '0;
			n_phase_q <= '0;
			v_addr_q  <= '0;
			n_addr_q  <= '0;
			v_comp_q  <= '{default: '0};
			n_comp_q  <= '{default: '0};
			v_chain_q <= '0;
			n_chain_q <= '0;
			step_q    <= '0;
			dfail_q   <= 1'b0;
			nbad_q    <= 1'b0;
			vbad_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (func)
							imf_pkg::FUNC_START: begin
								sticky_q  <= imf_pkg::ERR_OK;
								v_ent_q   <= '0;
								n_ent_q   <= '0;
								v_phase_q <= '0;
								n_phase_q <= '0;
								v_addr_q  <= '0;
								n_addr_q  <= '0;
								v_comp_q  <= '{default: '0};
								n_comp_q  <= '{default: '0};
								v_chain_q <= '0;
								n_chain_q <= '0;
							end
							imf_pkg::FUNC_LOAD_V: begin
								if (v_full) begin
									if (sticky_q == imf_pkg::ERR_OK) begin
										sticky_q <= imf_pkg::ERR_FULL;
									end
								end else begin
									if (xor_mode) begin
										v_comp_q[v_phase_q] <= v_word;
									end
									v_addr_q <= v_addr_q + imf_pkg::V_ADDR_W'(1);
									if (v_phase_q == 2'd2) begin
										v_phase_q <= '0;
										v_ent_q   <= v_ent_q + V_CNT_W_L'(1);
									end else begin
										v_phase_q <= v_phase_q + 2'd1;
									end
								end
							end
							imf_pkg::FUNC_LOAD_N: begin
								if (n_full) begin
									if (sticky_q == imf_pkg::ERR_OK) begin
										sticky_q <= imf_pkg::ERR_FULL;
									end
								end else begin
									if (xor_mode) begin
										n_comp_q[n_phase_q] <= n_word;
									end
									n_addr_q <= n_addr_q + imf_pkg::N_ADDR_W'(1);
									if (n_phase_q == 2'd2) begin
										n_phase_q <= '0;
										n_ent_q   <= n_ent_q + N_CNT_W_L'(1);
									end else begin
										n_phase_q <= n_phase_q + 2'd1;
									end
								end
							end
							default: begin
								step_q  <= '0;
								dfail_q <= 1'b0;
								nbad_q  <= 1'b0;
								vbad_q  <= 1'b0;
								state_q <= F_DEC;
							end
						endcase
					end
				end
				F_DEC: begin
					// one reference per cycle: normal, then corners a, b, c
					if (step_q == 2'd0) begin
						n_chain_q <= dec.chain;
						nbad_q    <= bad_now;
					end else begin
						v_chain_q <= dec.chain;
						if (bad_now) begin
							vbad_q <= 1'b1;
						end
					end
					if (!dec.ok) begin
						dfail_q <= 1'b1;
					end
					if (step_q == 2'd3) begin
						state_q <= F_PUSH;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						sticky_q <= err_new;
						state_q  <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/imf_back.sv =====
// ----------------------------------------------------------------------------
// imf_back
// Reads dictionary entries for each queued face and emits its 13 words.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         job_valid,
	input  wire imf_pkg::face_job_t           job,
	output      logic                         job_pop,
	output      logic                         nrm_re,
	output      logic [imf_pkg::N_ADDR_W-1:0] nrm_raddr,
	input  wire logic [31:0]                  nrm_rdata,
	output      logic                         vtx_re,
	output      logic [imf_pkg::V_ADDR_W-1:0] vtx_raddr,
	input  wire logic [31:0]                  vtx_rdata,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      imf_pkg::out_item_t           out_item,
	output      logic                         busy
);

	typedef enum logic [2:0] {C_NRM, C_VA, C_VB, C_VC, C_ATTR} corner_t;

	logic               job_v_q;
	imf_pkg::face_job_t job_q;
	corner_t            corner_q;
	logic [1:0]         comp_q;

	logic        word_v_s1;
	corner_t     corner_s1;
	logic [2:0]  err_s1;
	logic [15:0] attr_s1;

	logic               out_v_q;
	imf_pkg::out_item_t out_q;
	logic               skid_v_q;
	imf_pkg::out_item_t skid_q;

	logic                         take;
	logic [1:0]                   inflight;
	logic                         room;
	logic                         issue;
	logic                         last_issue;
	logic [imf_pkg::V_IDX_W-1:0]  vidx_sel;
	logic [31:0]                  word_val;
	imf_pkg::out_item_t           s1_item;
	logic                         out_free;

	assign take = out_v_q && !out_stall;
	// words in flight after this cycle's hand-off must fit in out + skid
	assign inflight   = {1'b0, word_v_s1} + {1'b0, out_v_q} + {1'b0, skid_v_q}
	                  - {1'b0, take};
	assign room       = (inflight < 2'd2);
	assign issue      = job_v_q && room;
	assign last_issue = issue && (corner_q == C_ATTR);
	assign job_pop    = job_valid && (!job_v_q || last_issue);

	always_comb begin
		case (corner_q)
			C_VA:    vidx_sel = job_q.vidx[0];
			C_VB:    vidx_sel = job_q.vidx[1];
			default: vidx_sel = job_q.vidx[2];
		endcase
	end

	assign nrm_re    = issue && (corner_q == C_NRM);
	assign nrm_raddr = imf_pkg::N_ADDR_W'({job_q.nidx, 1'b0}) + imf_pkg::N_ADDR_W'(job_q.nidx)
	                 + imf_pkg::N_ADDR_W'(comp_q);
	assign vtx_re    = issue && ((corner_q == C_VA) || (corner_q == C_VB) || (corner_q == C_VC));
	assign vtx_raddr = imf_pkg::V_ADDR_W'({vidx_sel, 1'b0}) + imf_pkg::V_ADDR_W'(vidx_sel)
	                 + imf_pkg::V_ADDR_W'(comp_q);

	always_comb begin
		if (err_s1 != imf_pkg::ERR_OK) begin
			word_val = '0;
		end else if (corner_s1 == C_NRM) begin
			word_val = nrm_rdata;
		end else if (corner_s1 == C_ATTR) begin
			word_val = {16'h0000, attr_s1};
		end else begin
			word_val = vtx_rdata;
		end
	end

	assign s1_item.word = word_val;
	assign s1_item.err  = err_s1;
	assign s1_item.last = (corner_s1 == C_ATTR);

	assign out_free  = !out_v_q || take;
	assign out_valid = out_v_q;
	assign out_item  = out_q;
	assign busy      = job_v_q || word_v_s1;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (issue) begin
			corner_s1 <= corner_q;
			err_s1    <= job_q.err;
			attr_s1   <= job_q.attr;
		end
		if (out_free) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (word_v_s1) begin
					skid_q <= s1_item;
				end
			end else if (word_v_s1) begin
				out_q <= s1_item;
			end
		end else if (word_v_s1) begin
			skid_q <= s1_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q   <= 1'b0;
			corner_q  <= C_NRM;
			comp_q    <= '0;
			word_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
			skid_v_q  <= 1'b0;
		end else begin
			if (job_pop) begin
				job_v_q <= 1'b1;
			end else if (last_issue) begin
				job_v_q <= 1'b0;
			end
			if (issue) begin
				if (corner_q == C_ATTR) begin
					corner_q <= C_NRM;
					comp_q   <= '0;
				end else if (comp_q == 2'd2) begin
					corner_q <= corner_t'(corner_q + 3'd1);
					comp_q   <= '0;
				end else begin
					comp_q <= comp_q + 2'd1;
				end
			end
			word_v_s1 <= issue;
			if (out_free) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= word_v_s1;
				end else begin
					out_v_q <= word_v_s1;
				end
			end else if (word_v_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_mesh_face_expander_core.sv =====
// ----------------------------------------------------------------------------
// indexed_mesh_face_expander_core
// Rebuilds STL triangle records from vertex and normal dictionaries.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | func, data_word, vertex_ref_a/b/c, attribute_bits
//  out     | out_valid/out_stall| out_word, error_code, last
//  cfg     | cfg_we             | cfg_wdata (decode_mode)
//
//  Start and load items do not leave idle; a start waits until queued faces drain.
//  A face holds the front end through accept, four reference decodes
//  (one per cycle) and the queue push.
//  The emitter sends one word per cycle while out_stall is low, 13 words per face.
//  Reset clears all control state; dictionary RAMs need no clearing pass.
//  out_stall holds words in the output and skid registers; a full job
//  queue then stalls the front end.
`default_nettype none

`include "assert_macros.svh"

module indexed_mesh_face_expander_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] data_word,
	input  wire logic [31:0] vertex_ref_a,
	input  wire logic [31:0] vertex_ref_b,
	input  wire logic [31:0] vertex_ref_c,
	input  wire logic [15:0] attribute_bits,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] out_word,
	output      logic [2:0]  error_code,
	output      logic        last
);

	logic               q_full;
	logic               q_not_empty;
	logic               job_push;
	logic               job_pop;
	imf_pkg::face_job_t push_job;
	imf_pkg::face_job_t head_job;
	imf_pkg::vtx_wr_t   vtx_wr;
	imf_pkg::nrm_wr_t   nrm_wr;
	logic               back_busy;
	logic               drained;

	logic                         nrm_re;
	logic [imf_pkg::N_ADDR_W-1:0] nrm_raddr;
	logic [31:0]                  nrm_rdata;
	logic                         vtx_re;
	logic [imf_pkg::V_ADDR_W-1:0] vtx_raddr;
	logic [31:0]                  vtx_rdata;
	imf_pkg::out_item_t           out_item;

	// no dictionary reads outstanding once this is high
	assign drained = !q_not_empty && !back_busy;

	imf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.data_word      (data_word),
		.vertex_ref_a   (vertex_ref_a),
		.vertex_ref_b   (vertex_ref_b),
		.vertex_ref_c   (vertex_ref_c),
		.attribute_bits (attribute_bits),
		.drained        (drained),
		.q_full         (q_full),
		.job_push       (job_push),
		.job            (push_job),
		.vtx_wr         (vtx_wr),
		.nrm_wr         (nrm_wr)
	);

	imf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (job_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	imf_ram #(
		.WIDTH (32),
		.DEPTH (imf_pkg::VERTEX_WORDS)
	) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_wr.we),
		.waddr (vtx_wr.addr),
		.wdata (vtx_wr.data),
		.re    (vtx_re),
		.raddr (vtx_raddr),
		.rdata (vtx_rdata)
	);

	imf_ram #(
		.WIDTH (32),
		.DEPTH (imf_pkg::NORMAL_WORDS)
	) u_nrm_ram (
		.clk   (clk),
		.we    (nrm_wr.we),
		.waddr (nrm_wr.addr),
		.wdata (nrm_wr.data),
		.re    (nrm_re),
		.raddr (nrm_raddr),
		.rdata (nrm_rdata)
	);

	imf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (head_job),
		.job_pop   (job_pop),
		.nrm_re    (nrm_re),
		.nrm_raddr (nrm_raddr),
		.nrm_rdata (nrm_rdata),
		.vtx_re    (vtx_re),
		.vtx_raddr (vtx_raddr),
		.vtx_rdata (vtx_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.busy      (back_busy)
	);

	assign out_word   = out_item.word;
	assign error_code = out_item.err;
	assign last       = out_item.last;

	`IMF_ASSERT_IMP(a_err_zero_word, out_valid && (error_code != imf_pkg::ERR_OK),
		out_word == 32'd0, "erroring face emitted a nonzero word")
	`IMF_ASSERT_IMP(a_push_not_full, job_push, !q_full, "job queue overflow")
	`IMF_ASSERT_IMP(a_start_drained, in_valid && !in_stall && (func == imf_pkg::FUNC_START),
		drained, "start accepted with faces still reading")
	`IMF_ASSERT_NXT(a_face_busy, in_valid && !in_stall && (func == imf_pkg::FUNC_FACE),
		in_stall, "front end took an item while decoding a face")

endmodule

`default_nettype wire
